// ===== hdl/vsds_pkg.sv =====
package vsds_pkg;

    // Default sizes handed to the top level parameters
    localparam int DEF_MAX_SIDE   = 64;
    localparam int DEF_MAX_LEVELS = 1024;
    localparam int DEF_DATA_WIDTH = 32;

    // Configuration port
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int SIDE_FIELD_W  = 7;
    localparam int DEPTH_FIELD_W = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PLANE_WIDTH     = 2'd0,
        REG_PLANE_HEIGHT    = 2'd1,
        REG_COLUMN_DEPTH    = 2'd2,
        REG_INV_SPACING_SQ  = 2'd3
    } cfg_reg_t;

    localparam int RESET_SIDE  = 64;
    localparam int RESET_DEPTH = 64;
    localparam int MIN_DEPTH   = 2;

    // Coefficient is unsigned Q16.16
    localparam int COEF_W     = 32;
    localparam logic [COEF_W-1:0] RESET_COEF = 32'd65536;
    localparam int FRAC_W     = 16;
    localparam int ROUND_HALF = 32768;

    // Multiplier split: low part is MUL_W bits wide
    localparam int MUL_W = 32;

    // Register stages inside one scale lane
    localparam int SCALE_LAT = 4;

    // Result pairs held at the output
    localparam int OUTQ_DEPTH = 16;

    // Per-item result control: lower level, top level, end of field
    typedef struct packed {
        logic v0;
        logic v1;
        logic last;
    } res_ctl_t;

endpackage

// ===== hdl/vsds_ram.sv =====
module vsds_ram
    import vsds_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_SIDE * DEF_MAX_SIDE,
    parameter int WIDTH  = DEF_DATA_WIDTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/vsds_scale.sv =====
module vsds_scale
    import vsds_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                         clk,
    input  logic [COEF_W-1:0]            coef,
    input  logic signed [DATA_WIDTH+1:0] diff,
    output logic [DATA_WIDTH-1:0]        result
);

    localparam int MAG_W = DATA_WIDTH + 2;
    localparam int HI_W  = (MAG_W > MUL_W) ? (MAG_W - MUL_W) : 1;
    localparam int PAD_W = MUL_W + HI_W;
    localparam int LO_P  = MUL_W + COEF_W;
    localparam int HI_P  = HI_W + COEF_W;
    localparam int SUM_W = PAD_W + COEF_W;
    localparam int Q_W   = SUM_W - FRAC_W;
    localparam logic [Q_W-1:0] LIM = Q_W'(1) << (DATA_WIDTH - 1);

    logic signed [MAG_W-1:0] diff_reg;
    logic [PAD_W-1:0]        mag_reg;
    logic                    neg1_reg;
    logic [LO_P-1:0]         plo_reg;
    logic [HI_P-1:0]         phi_reg;
    logic                    neg2_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    neg3_reg;

    logic [MAG_W-1:0]      mag;
    logic [Q_W-1:0]        q;
    logic [DATA_WIDTH-1:0] q_lo;

    // Magnitude of the difference
    assign mag = diff_reg[MAG_W-1] ? (~diff_reg + MAG_W'(1)) : diff_reg;

    always_ff @(posedge clk)
    begin
        diff_reg <= diff;
        mag_reg  <= PAD_W'(mag);
        neg1_reg <= diff_reg[MAG_W-1];
        plo_reg  <= LO_P'(mag_reg[MUL_W-1:0]) * LO_P'(coef);
        phi_reg  <= HI_P'(mag_reg[PAD_W-1:MUL_W]) * HI_P'(coef);
        neg2_reg <= neg1_reg;
        sum_reg  <= (SUM_W'(phi_reg) << MUL_W) + SUM_W'(plo_reg) + SUM_W'(ROUND_HALF);
        neg3_reg <= neg2_reg;
    end

    // Drop the fraction, then clamp to the signed range
    assign q    = sum_reg[SUM_W-1:FRAC_W];
    assign q_lo = q[DATA_WIDTH-1:0];

    always_comb
    begin
        if (neg3_reg)
        begin
            if (q > LIM)
                result = LIM[DATA_WIDTH-1:0];
            else
                result = ~q_lo + DATA_WIDTH'(1);
        end
        else
        begin
            if (q >= LIM)
                result = LIM[DATA_WIDTH-1:0] - DATA_WIDTH'(1);
            else
                result = q_lo;
        end
    end

endmodule

// ===== hdl/vsds_outq.sv =====
module vsds_outq
    import vsds_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  res_ctl_t              push_ctl,
    input  logic [DATA_WIDTH-1:0] push_val0,
    input  logic [DATA_WIDTH-1:0] push_val1,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [DATA_WIDTH-1:0] value,
    output logic                  last
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    logic [DATA_WIDTH-1:0] val0_mem [OUTQ_DEPTH];
    logic [DATA_WIDTH-1:0] val1_mem [OUTQ_DEPTH];
    res_ctl_t              ctl_mem  [OUTQ_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             half_reg, half_next;
    logic             out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic             last_reg, last_next;
    logic             load;
    res_ctl_t         head_ctl;

    assign head_ctl = ctl_mem[rd_ptr_reg];
    assign load     = (!out_valid_reg || out_ready) && (count_reg != '0);

    always_comb
    begin
        pop            = 1'b0;
        half_next      = half_reg;
        value_next     = value_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (head_ctl.v0 && !half_reg)
            begin
                value_next = val0_mem[rd_ptr_reg];
                last_next  = 1'b0;
                if (head_ctl.v1)
                    half_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                value_next = val1_mem[rd_ptr_reg];
                last_next  = head_ctl.last;
                half_next  = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            val0_mem[wr_ptr_reg] <= push_val0;
            val1_mem[wr_ptr_reg] <= push_val1;
            ctl_mem[wr_ptr_reg]  <= push_ctl;
        end
        value_reg <= value_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg     <= count_reg + CNT_W'(push) - CNT_W'(pop);
            half_reg      <= half_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/vertical_second_derivative_stencil.sv =====
// Channel   Signals                          Transfer when
// cfg       cfg_we, cfg_index, cfg_data      cfg_we high (no wait)
// in        in_valid, in_ready, sample       in_valid && in_ready
// out       out_valid, out_ready, value,     out_valid && out_ready
//           last
//
// One sample per cycle is sustained while in_ready is high; a result passes
// the store read and stencil stage, four scale stages and the output queue.
// In the last level each sample yields two results and the output, one result
// per cycle while out_ready is high, paces input to one sample per two results there.
// Reset clears counters, config, valid flags and queue, not the plane stores.
// in_ready drops only when the output queue cannot take all items in flight.
module vertical_second_derivative_stencil
    import vsds_pkg::*;
#(
    parameter int MAX_SIDE   = DEF_MAX_SIDE,
    parameter int MAX_LEVELS = DEF_MAX_LEVELS,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [DATA_WIDTH-1:0]  sample,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [DATA_WIDTH-1:0]  value,
    output logic                   last
);

    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SIDE_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SIDE_CNT_W  = $clog2(MAX_SIDE + 1);
    localparam int LVL_W       = $clog2(MAX_LEVELS);
    localparam int LVL_CNT_W   = $clog2(MAX_LEVELS + 1);
    localparam int DIFF_W      = DATA_WIDTH + 2;
    localparam int RES_W       = $clog2(OUTQ_DEPTH + 1);
    localparam int RST_SIDE    = (RESET_SIDE > MAX_SIDE) ? MAX_SIDE : RESET_SIDE;
    localparam int RST_DEPTH   = (RESET_DEPTH > MAX_LEVELS) ? MAX_LEVELS : RESET_DEPTH;

    // ---------------------------------------------------------------
    // Configuration registers, sizes clamped on write
    // ---------------------------------------------------------------
    logic [SIDE_CNT_W-1:0] plane_width_reg, plane_height_reg, side_clamped;
    logic [LVL_CNT_W-1:0]  column_depth_reg, depth_clamped;
    logic [COEF_W-1:0]     coef_reg;
    logic [SIDE_FIELD_W-1:0]  side_field;
    logic [DEPTH_FIELD_W-1:0] depth_field;

    assign side_field  = cfg_data[SIDE_FIELD_W-1:0];
    assign depth_field = cfg_data[DEPTH_FIELD_W-1:0];

    always_comb
    begin
        if (side_field == '0)
            side_clamped = SIDE_CNT_W'(1);
        else if (32'(side_field) > 32'(MAX_SIDE))
            side_clamped = SIDE_CNT_W'(MAX_SIDE);
        else
            side_clamped = SIDE_CNT_W'(side_field);

        if (32'(depth_field) < 32'(MIN_DEPTH))
            depth_clamped = LVL_CNT_W'(MIN_DEPTH);
        else if (32'(depth_field) > 32'(MAX_LEVELS))
            depth_clamped = LVL_CNT_W'(MAX_LEVELS);
        else
            depth_clamped = LVL_CNT_W'(depth_field);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_width_reg  <= SIDE_CNT_W'(RST_SIDE);
            plane_height_reg <= SIDE_CNT_W'(RST_SIDE);
            column_depth_reg <= LVL_CNT_W'(RST_DEPTH);
            coef_reg         <= RESET_COEF;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PLANE_WIDTH:    plane_width_reg  <= side_clamped;
                REG_PLANE_HEIGHT:   plane_height_reg <= side_clamped;
                REG_COLUMN_DEPTH:   column_depth_reg <= depth_clamped;
                REG_INV_SPACING_SQ: coef_reg         <= cfg_data[COEF_W-1:0];
                default:            coef_reg         <= coef_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Position counters: x fastest, then y, then level
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] col_x_reg, col_x_next, row_y_reg, row_y_next;
    logic [LVL_W-1:0]  level_z_reg, level_z_next;
    logic              col_end, row_end, plane_end, top;
    logic [ADDR_W-1:0] idx;
    logic              accept;

    assign accept    = in_valid && in_ready;
    assign col_end   = (SIDE_CNT_W'(col_x_reg) + SIDE_CNT_W'(1)) >= plane_width_reg;
    assign row_end   = (SIDE_CNT_W'(row_y_reg) + SIDE_CNT_W'(1)) >= plane_height_reg;
    assign plane_end = col_end && row_end;
    assign top       = (LVL_CNT_W'(level_z_reg) + LVL_CNT_W'(1)) >= column_depth_reg;
    assign idx       = ADDR_W'(row_y_reg) * ADDR_W'(MAX_SIDE) + ADDR_W'(col_x_reg);

    always_comb
    begin
        col_x_next   = col_x_reg;
        row_y_next   = row_y_reg;
        level_z_next = level_z_reg;
        if (col_end)
        begin
            col_x_next = '0;
            if (row_end)
            begin
                row_y_next   = '0;
                level_z_next = top ? '0 : level_z_reg + LVL_W'(1);
            end
            else
            begin
                row_y_next = row_y_reg + SIDE_W'(1);
            end
        end
        else
        begin
            col_x_next = col_x_reg + SIDE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_x_reg   <= '0;
            row_y_reg   <= '0;
            level_z_reg <= '0;
        end
        else if (accept)
        begin
            col_x_reg   <= col_x_next;
            row_y_reg   <= row_y_next;
            level_z_reg <= level_z_next;
        end
    end

    // ---------------------------------------------------------------
    // Stencil stage: store data arrives, combine, write back.
    // Each column entry is read, combined and written back in one pass;
    // a forward path covers back-to-back samples on the same entry.
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [DATA_WIDTH-1:0] s1_sample_reg;
    logic [ADDR_W-1:0]     s1_idx_reg;
    logic                  s1_hit_reg;
    logic                  s1_first_reg;
    res_ctl_t              s1_ctl_reg;
    logic [DATA_WIDTH-1:0] fwd_cur_reg, fwd_prev_reg;

    logic [DATA_WIDTH-1:0] prev_rd, prev2_rd, prev_eff, prev2_eff;
    logic signed [DIFF_W-1:0] cur_x, prev_x, prev2_x, diff0, diff1;

    vsds_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_plane_before (
        .clk  (clk),
        .we   (s1_valid_reg),
        .waddr(s1_idx_reg),
        .wdata(s1_sample_reg),
        .raddr(idx),
        .rdata(prev_rd)
    );

    vsds_ram #(
        .DEPTH (STORE_DEPTH),
        .WIDTH (DATA_WIDTH),
        .ADDR_W(ADDR_W)
    ) u_plane_two_before (
        .clk  (clk),
        .we   (s1_valid_reg),
        .waddr(s1_idx_reg),
        .wdata(prev_eff),
        .raddr(idx),
        .rdata(prev2_rd)
    );

    // Take the previous sample's write-back when it hit the same entry
    assign prev_eff  = s1_hit_reg ? fwd_cur_reg  : prev_rd;
    assign prev2_eff = s1_hit_reg ? fwd_prev_reg : prev2_rd;

    assign cur_x   = DIFF_W'(signed'(s1_sample_reg));
    assign prev_x  = DIFF_W'(signed'(prev_eff));
    assign prev2_x = DIFF_W'(signed'(prev2_eff));

    // Second level uses a one-sided difference, upper levels the full stencil
    assign diff0 = s1_first_reg ? (cur_x - prev_x) : (prev2_x + cur_x - (prev_x <<< 1));
    // Top level: one-sided difference looking down
    assign diff1 = prev_x - cur_x;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg  <= sample;
            s1_idx_reg     <= idx;
            s1_hit_reg     <= s1_valid_reg && (s1_idx_reg == idx);
            s1_first_reg   <= (level_z_reg == LVL_W'(1));
            s1_ctl_reg.v0   <= (level_z_reg != '0);
            s1_ctl_reg.v1   <= (level_z_reg != '0) && top;
            s1_ctl_reg.last <= top && plane_end;
        end
        if (s1_valid_reg)
        begin
            fwd_cur_reg  <= s1_sample_reg;
            fwd_prev_reg <= prev_eff;
        end
    end

    // ---------------------------------------------------------------
    // Scale lanes: lower-level result and top-level result
    // ---------------------------------------------------------------
    logic [DATA_WIDTH-1:0] res0, res1;

    vsds_scale #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_scale_low (
        .clk   (clk),
        .coef  (coef_reg),
        .diff  (diff0),
        .result(res0)
    );

    vsds_scale #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_scale_top (
        .clk   (clk),
        .coef  (coef_reg),
        .diff  (diff1),
        .result(res1)
    );

    // Control travels beside the scale lanes
    logic     pipe_valid_reg [SCALE_LAT];
    res_ctl_t pipe_ctl_reg   [SCALE_LAT];
    res_ctl_t end_ctl;
    logic     end_valid, push, release_slot, pop;

    always_ff @(posedge clk)
    begin
        pipe_ctl_reg[0] <= s1_ctl_reg;
        for (int i = 1; i < SCALE_LAT; i++)
        begin
            pipe_ctl_reg[i] <= pipe_ctl_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < SCALE_LAT; i++)
            begin
                pipe_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            s1_valid_reg      <= accept;
            pipe_valid_reg[0] <= s1_valid_reg;
            for (int i = 1; i < SCALE_LAT; i++)
            begin
                pipe_valid_reg[i] <= pipe_valid_reg[i-1];
            end
        end
    end

    assign end_valid    = pipe_valid_reg[SCALE_LAT-1];
    assign end_ctl      = pipe_ctl_reg[SCALE_LAT-1];
    // Drop items of the first plane: they carry no result
    assign push         = end_valid && (end_ctl.v0 || end_ctl.v1);
    assign release_slot = end_valid && !(end_ctl.v0 || end_ctl.v1);

    // ---------------------------------------------------------------
    // Output queue and slot accounting
    // ---------------------------------------------------------------
    logic [RES_W-1:0] reserved_reg;

    vsds_outq #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ctl (end_ctl),
        .push_val0(res0),
        .push_val1(res1),
        .pop      (pop),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value    (value),
        .last     (last)
    );

    // Hold one queue slot per item from transfer until it leaves or is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_reg <= '0;
        end
        else
        begin
            reserved_reg <= reserved_reg + RES_W'(accept) - RES_W'(release_slot)
                            - RES_W'(pop);
        end
    end

    assign in_ready = reserved_reg < RES_W'(OUTQ_DEPTH);

endmodule
